// ===== design/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, off while reset is asserted.
`define TRBM_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: check failed");

// Clocked check that also holds during reset.
`define TRBM_ASSERT_NR(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("%m: check failed");

`endif

// ===== design/trbm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package trbm_pkg;

  localparam int IDX_W     = 6;   // node index field width
  localparam int CNT_W     = 7;   // node_count register width
  localparam int SUCC_W    = 64;  // successors field width
  localparam int NODES_DEF = 64;

  localparam logic [CNT_W-1:0] NODE_COUNT_RST = 7'd64;

  typedef enum logic [1:0] {
    ACT_CLEAR = 2'd0,
    ACT_EDGE  = 2'd1,
    ACT_RUN   = 2'd2
  } action_e;

  typedef enum logic [2:0] {
    OP_IDLE,
    OP_CLEAR,
    OP_EDGE_WR,
    OP_COPY_WR,
    OP_PIV_LD,
    OP_CLOSE_WR,
    OP_REDUCE_WR,
    OP_OUT_LD
  } dp_op_e;

  typedef struct packed {
    dp_op_e           op;
    logic [IDX_W-1:0] addr;     // row read this cycle, written on a write op
    logic [IDX_W-1:0] bit_idx;  // column / pivot row
    logic             last;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

// ===== design/trbm_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface trbm_in_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  action;
  logic [trbm_pkg::IDX_W-1:0]  src;
  logic [trbm_pkg::IDX_W-1:0]  dst;

  modport source (output valid, action, src, dst, input ready);
  modport sink   (input valid, action, src, dst, output ready);
endinterface

interface trbm_out_if;
  logic                        valid;
  logic                        ready;
  logic [trbm_pkg::IDX_W-1:0]  row;
  logic [trbm_pkg::SUCC_W-1:0] successors;
  logic                        last;

  modport source (output valid, row, successors, last, input ready);
  modport sink   (input valid, row, successors, last, output ready);
endinterface

interface trbm_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [trbm_pkg::CNT_W-1:0]  data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

// ===== design/transitive_reduction_bitmatrix.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Transitive reduction of a directed graph of up to NODES nodes. Requests on
// in_i: clear, add edge src->dst (ignored when an index is not below NODES),
// run (emits node_count result rows, row 0 first, last set on the final one).
// In a run over n active nodes the closure and the reduction each walk n pivot
// rows, and every row update is a read then a write on the single-port work
// matrix memory; each output row is read, then loaded once out_o is free.
// node_count (cfg_i, reset 64) saturates at NODES. The user must write it only
// while no run is in flight; the block itself does not enforce this.
module transitive_reduction_bitmatrix #(
  parameter int NODES = trbm_pkg::NODES_DEF
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  trbm_in_if.sink     in_i,
  trbm_out_if.source  out_o,
  trbm_cfg_if.sink    cfg_i
);

  localparam int NW   = $clog2(NODES + 1);
  localparam int CntW = trbm_pkg::CNT_W;

  logic [CntW-1:0]  node_count_q;
  logic [NW-1:0]    n_eff;
  trbm_pkg::cmd_t   cmd;
  trbm_pkg::sts_t   sts;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= trbm_pkg::NODE_COUNT_RST;
    end else if (cfg_i.valid && cfg_i.ready) begin
      node_count_q <= cfg_i.data;
    end
  end

  assign n_eff = (node_count_q > CntW'(NODES)) ? NW'(NODES) : NW'(node_count_q);

  trbm_ctrl #(.NODES(NODES)) u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .n_i    (n_eff),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  trbm_datapath #(.NODES(NODES)) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .n_i    (n_eff),
    .sts_o  (sts),
    .out_o  (out_o)
  );

endmodule

`default_nettype wire

// ===== design/trbm_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module trbm_ctrl #(
  parameter int NODES = trbm_pkg::NODES_DEF,
  localparam int NW   = $clog2(NODES + 1)
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  trbm_in_if.sink          in_i,
  input  wire [NW-1:0]     n_i,
  input  trbm_pkg::sts_t   sts_i,
  output trbm_pkg::cmd_t   cmd_o
);

  localparam int IdxW = trbm_pkg::IDX_W;
  localparam int CntW = trbm_pkg::CNT_W;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EDGE_WR,
    S_COPY_RD,
    S_COPY_WR,
    S_PIV_RD,
    S_PIV_LD,
    S_UPD_RD,
    S_UPD_WR,
    S_OUT_RD,
    S_OUT_LD
  } state_e;

  state_e          state_q, state_d;
  logic [NW-1:0]   i_q, i_d, k_q, k_d;
  logic            reduce_q, reduce_d;
  logic [IdxW-1:0] src_q, src_d, dst_q, dst_d;

  logic accept, edge_ok, last_i, last_k;

  assign in_i.ready = (state_q == S_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign edge_ok    = ({1'b0, in_i.src} < CntW'(NODES)) && ({1'b0, in_i.dst} < CntW'(NODES));
  assign last_i     = (NW'(i_q + 1'b1) == n_i);
  assign last_k     = (NW'(k_q + 1'b1) == n_i);

  always_comb begin
    state_d  = state_q;
    i_d      = i_q;
    k_d      = k_q;
    reduce_d = reduce_q;
    src_d    = src_q;
    dst_d    = dst_q;

    cmd_o.op      = trbm_pkg::OP_IDLE;
    cmd_o.addr    = IdxW'(i_q);
    cmd_o.bit_idx = IdxW'(k_q);
    cmd_o.last    = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        // read the source row early so an edge write can follow directly
        cmd_o.addr = in_i.src;
        if (accept) begin
          case (in_i.action)
            trbm_pkg::ACT_CLEAR: cmd_o.op = trbm_pkg::OP_CLEAR;
            trbm_pkg::ACT_EDGE: begin
              if (edge_ok) begin
                src_d   = in_i.src;
                dst_d   = in_i.dst;
                state_d = S_EDGE_WR;
              end
            end
            trbm_pkg::ACT_RUN: begin
              if (n_i != '0) begin
                i_d     = '0;
                state_d = S_COPY_RD;
              end
            end
            default: ;
          endcase
        end
      end
      S_EDGE_WR: begin
        cmd_o.op      = trbm_pkg::OP_EDGE_WR;
        cmd_o.addr    = src_q;
        cmd_o.bit_idx = dst_q;
        state_d       = S_IDLE;
      end
      S_COPY_RD: state_d = S_COPY_WR;
      S_COPY_WR: begin
        cmd_o.op = trbm_pkg::OP_COPY_WR;
        if (last_i) begin
          k_d      = '0;
          reduce_d = 1'b0;
          state_d  = S_PIV_RD;
        end else begin
          i_d     = NW'(i_q + 1'b1);
          state_d = S_COPY_RD;
        end
      end
      S_PIV_RD: begin
        cmd_o.addr = IdxW'(k_q);
        state_d    = S_PIV_LD;
      end
      S_PIV_LD: begin
        cmd_o.addr = IdxW'(k_q);
        cmd_o.op   = trbm_pkg::OP_PIV_LD;
        i_d        = '0;
        state_d    = S_UPD_RD;
      end
      S_UPD_RD: state_d = S_UPD_WR;
      S_UPD_WR: begin
        cmd_o.op = reduce_q ? trbm_pkg::OP_REDUCE_WR : trbm_pkg::OP_CLOSE_WR;
        if (last_i) begin
          i_d = '0;
          if (last_k) begin
            k_d = '0;
            if (reduce_q) begin
              state_d = S_OUT_RD;
            end else begin
              reduce_d = 1'b1;
              state_d  = S_PIV_RD;
            end
          end else begin
            k_d     = NW'(k_q + 1'b1);
            state_d = S_PIV_RD;
          end
        end else begin
          i_d     = NW'(i_q + 1'b1);
          state_d = S_UPD_RD;
        end
      end
      S_OUT_RD: state_d = S_OUT_LD;
      S_OUT_LD: begin
        if (sts_i.out_free) begin
          cmd_o.op   = trbm_pkg::OP_OUT_LD;
          cmd_o.last = last_i;
          if (last_i) begin
            state_d = S_IDLE;
          end else begin
            i_d     = NW'(i_q + 1'b1);
            state_d = S_OUT_RD;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      i_q      <= '0;
      k_q      <= '0;
      reduce_q <= 1'b0;
      src_q    <= '0;
      dst_q    <= '0;
    end else begin
      state_q  <= state_d;
      i_q      <= i_d;
      k_q      <= k_d;
      reduce_q <= reduce_d;
      src_q    <= src_d;
      dst_q    <= dst_d;
    end
  end

endmodule

`default_nettype wire

// ===== design/trbm_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module trbm_datapath #(
  parameter int NODES = trbm_pkg::NODES_DEF,
  localparam int NW   = $clog2(NODES + 1)
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  trbm_pkg::cmd_t   cmd_i,
  input  wire [NW-1:0]     n_i,
  output trbm_pkg::sts_t   sts_o,
  trbm_out_if.source       out_o
);

  localparam int AW    = $clog2(NODES);
  localparam int IdxW  = trbm_pkg::IDX_W;
  localparam int SuccW = trbm_pkg::SUCC_W;

  logic [NODES-1:0] orig_mem [NODES];
  logic [NODES-1:0] work_mem [NODES];
  logic [NODES-1:0] orig_vld_q;

  logic [NODES-1:0] orig_rd_q, work_rd_q, piv_q, piv_d;
  logic             ov_q;

  logic [AW-1:0]    addr, bidx;
  logic [NODES-1:0] orig_eff, cols, bit_one;
  logic [NODES-1:0] orig_wdata, work_wdata;
  logic             we_orig, we_work, work_hit;

  logic             out_valid_q, out_last_q;
  logic [IdxW-1:0]  out_row_q;
  logic [SuccW-1:0] out_succ_q;

  assign addr     = cmd_i.addr[AW-1:0];
  assign bidx     = cmd_i.bit_idx[AW-1:0];
  assign orig_eff = ov_q ? orig_rd_q : '0;   // row never written since clear reads as zero
  assign bit_one  = NODES'(1) << bidx;
  assign work_hit = work_rd_q[bidx];

  always_comb begin
    for (int c = 0; c < NODES; c++) begin
      cols[c] = (NW'(c) < n_i);
    end
  end

  always_comb begin
    we_orig    = 1'b0;
    we_work    = 1'b0;
    orig_wdata = orig_eff | bit_one;
    work_wdata = orig_eff & cols;
    piv_d      = piv_q;
    case (cmd_i.op)
      trbm_pkg::OP_EDGE_WR: we_orig = 1'b1;
      trbm_pkg::OP_COPY_WR: we_work = 1'b1;
      trbm_pkg::OP_PIV_LD:  piv_d   = work_rd_q;
      trbm_pkg::OP_CLOSE_WR: begin
        we_work    = work_hit;
        work_wdata = work_rd_q | piv_q;
      end
      trbm_pkg::OP_REDUCE_WR: begin
        we_work    = work_hit;
        work_wdata = work_rd_q & ~piv_q;
      end
      default: ;
    endcase
    // pivot row rewritten by its own update: later rows see the new value
    if (we_work && (addr == bidx) &&
        (cmd_i.op == trbm_pkg::OP_CLOSE_WR || cmd_i.op == trbm_pkg::OP_REDUCE_WR)) begin
      piv_d = work_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    orig_rd_q <= orig_mem[addr];
    work_rd_q <= work_mem[addr];
    ov_q      <= orig_vld_q[addr];
    piv_q     <= piv_d;
    if (we_orig) orig_mem[addr] <= orig_wdata;
    if (we_work) work_mem[addr] <= work_wdata;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      orig_vld_q <= '0;
    end else if (cmd_i.op == trbm_pkg::OP_CLEAR) begin
      orig_vld_q <= '0;
    end else if (we_orig) begin
      orig_vld_q[addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.op == trbm_pkg::OP_OUT_LD) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == trbm_pkg::OP_OUT_LD) begin
      out_row_q  <= cmd_i.addr;
      out_succ_q <= SuccW'(orig_eff & work_rd_q);
      out_last_q <= cmd_i.last;
    end
  end

  assign sts_o.out_free  = !out_valid_q || out_o.ready;
  assign out_o.valid      = out_valid_q;
  assign out_o.row        = out_row_q;
  assign out_o.successors = out_succ_q;
  assign out_o.last       = out_last_q;

endmodule

`default_nettype wire

// ===== design/trbm_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module trbm_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        in_ready_i,
  input wire        out_valid_i,
  input wire        out_ready_i,
  input wire [5:0]  out_row_i,
  input wire [63:0] out_succ_i,
  input wire        out_last_i
);

  `TRBM_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i |=> out_valid_i)
  `TRBM_ASSERT(a_out_stable, clk_i, rst_ni, out_valid_i && !out_ready_i |=> $stable(out_row_i) && $stable(out_succ_i) && $stable(out_last_i))
  // a run keeps the requests off until its final row is queued
  `TRBM_ASSERT(a_busy_mid_run, clk_i, rst_ni, out_valid_i && !out_last_i |-> !in_ready_i)
  `TRBM_ASSERT(a_gap_after_last, clk_i, rst_ni, out_valid_i && out_ready_i && out_last_i |=> !out_valid_i)
  // a node with a path to itself loses its whole row, so no self edge survives
  `TRBM_ASSERT(a_no_self_edge, clk_i, rst_ni, !out_valid_i || !out_succ_i[out_row_i])

endmodule

bind transitive_reduction_bitmatrix trbm_checker u_trbm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_row_i   (out_o.row),
  .out_succ_i  (out_o.successors),
  .out_last_i  (out_o.last)
);

`default_nettype wire

// ===== verif/tb_transitive_reduction_bitmatrix.sv =====
`timescale 1ns / 1ps

module tb_transitive_reduction_bitmatrix;
  import trbm_pkg::*;

  localparam int          MAX_NODES   = NODES_DEF;
  localparam int unsigned CYCLE_LIMIT = 30_000_000;
  localparam int          SETTLE      = 20;   // covers a clear or an edge load
  localparam logic [1:0]  ACT_SPARE   = 2'd3; // no operation, ignored

  typedef enum logic {STEP_REQ, STEP_CFG} step_kind_e;
  typedef enum logic {CHK_MODEL, CHK_TYPED} chk_e;
  typedef enum logic [1:0] {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_e;

  typedef struct packed {
    step_kind_e       kind;
    logic [1:0]       act;
    logic [IDX_W-1:0] src;
    logic [IDX_W-1:0] dst;
    logic [CNT_W-1:0] cnt;
    chk_e             chk;
    logic [IDX_W-1:0] exp_row;   // typed check: only this row is nonzero
    logic [63:0]      exp_succ;
  } dir_step_t;

  typedef struct packed {
    idle_e            mode;
    logic [CNT_W-1:0] cnt;
    logic [8:0]       items;
  } phase_t;

  typedef struct packed {
    logic [IDX_W-1:0]  row;
    logic [SUCC_W-1:0] succ;
    logic              last;
  } row_t;

  localparam int N_DIR = 26;
  localparam dir_step_t DIR_STEPS [N_DIR] = '{
    // reset graph, 64 nodes
    '{STEP_REQ, ACT_RUN,   6'd0,  6'd0,  7'd0,   CHK_TYPED, 6'd0, 64'd0},
    '{STEP_REQ, ACT_EDGE,  6'd0,  6'd63, 7'd0,   CHK_MODEL, 6'd0, 64'd0},
    '{STEP_REQ, ACT_RUN,   6'd63, 6'd63, 7'd0,   CHK_TYPED, 6'd0, 64'h8000_0000_0000_0000},
    '{STEP_REQ, ACT_CLEAR, 6'd63, 6'd0,  7'd0,   CHK_MODEL, 6'd0, 64'd0},
    '{STEP_REQ, ACT_RUN,   6'd21, 6'd42, 7'd0,   CHK_TYPED, 6'd0, 64'd0},
    // small graph: implied edge 0->2, node 5 outside the count
    '{STEP_CFG, ACT_CLEAR, 6'd0,  6'd0,  7'd4,   CHK_MODEL, 6'd0, 64'd0},
    '{STEP_REQ, ACT_EDGE,  6'd0,  6'd1,  7'd0,   CHK_MODEL, 6'd0, 64'd0},
    '{STEP_REQ, ACT_EDGE,  6'd1,  6'd2,  7'd0,   CHK_MODEL, 6'd0, 64'd0},
    '{STEP_REQ, ACT_EDGE,  6'd0,  6'd2,  7'd0,   CHK_MODEL, 6'd0, 64'd0},
    '{STEP_REQ, ACT_EDGE,  6'd2,  6'd3,  7'd0,   CHK_MODEL, 6'd0, 64'd0},
    '{STEP_REQ, ACT_EDGE,  6'd5,  6'd1,  7'd0,   CHK_MODEL, 6'd0, 64'd0},
    '{STEP_REQ, ACT_SPARE, 6'd63, 6'd63, 7'd0,   CHK_MODEL, 6'd0, 64'd0},
    '{STEP_REQ, ACT_RUN,   6'd0,  6'd0,  7'd0,   CHK_MODEL, 6'd0, 64'd0},
    '{STEP_REQ, ACT_RUN,   6'd63, 6'd63, 7'd0,   CHK_MODEL, 6'd0, 64'd0},
    // close a cycle and add a self loop
    '{STEP_REQ, ACT_EDGE,  6'd3,  6'd0,  7'd0,   CHK_MODEL, 6'd0, 64'd0},
    '{STEP_REQ, ACT_EDGE,  6'd2,  6'd2,  7'd0,   CHK_MODEL, 6'd0, 64'd0},
    '{STEP_REQ, ACT_RUN,   6'd0,  6'd0,  7'd0,   CHK_MODEL, 6'd0, 64'd0},
    // zero nodes: no rows
    '{STEP_CFG, ACT_CLEAR, 6'd0,  6'd0,  7'd0,   CHK_MODEL, 6'd0, 64'd0},
    '{STEP_REQ, ACT_RUN,   6'd0,  6'd0,  7'd0,   CHK_MODEL, 6'd0, 64'd0},
    // count above the node limit saturates
    '{STEP_CFG, ACT_CLEAR, 6'd0,  6'd0,  7'd127, CHK_MODEL, 6'd0, 64'd0},
    '{STEP_REQ, ACT_RUN,   6'd0,  6'd0,  7'd0,   CHK_MODEL, 6'd0, 64'd0},
    // single node with a self loop
    '{STEP_CFG, ACT_CLEAR, 6'd0,  6'd0,  7'd1,   CHK_MODEL, 6'd0, 64'd0},
    '{STEP_REQ, ACT_EDGE,  6'd0,  6'd0,  7'd0,   CHK_MODEL, 6'd0, 64'd0},
    '{STEP_REQ, ACT_EDGE,  6'd63, 6'd63, 7'd0,   CHK_MODEL, 6'd0, 64'd0},
    '{STEP_REQ, ACT_RUN,   6'd0,  6'd0,  7'd0,   CHK_MODEL, 6'd0, 64'd0},
    '{STEP_REQ, ACT_CLEAR, 6'd0,  6'd0,  7'd0,   CHK_MODEL, 6'd0, 64'd0}
  };

  localparam int N_PHASES = 7;
  localparam phase_t PHASES [N_PHASES] = '{
    '{IDLE_NONE, 7'd8,  9'd45},
    '{IDLE_SEND, 7'd5,  9'd40},
    '{IDLE_RECV, 7'd6,  9'd40},
    '{IDLE_BOTH, 7'd3,  9'd40},
    '{IDLE_NONE, 7'd2,  9'd30},
    '{IDLE_RECV, 7'd64, 9'd16},
    '{IDLE_BOTH, 7'd16, 9'd30}
  };

  logic clk_i;
  logic rst_ni;

  trbm_in_if  in_if ();
  trbm_out_if out_if ();
  trbm_cfg_if cfg_if ();

  transitive_reduction_bitmatrix i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  // Mirror of the block: loaded edges and the node count register.
  logic [63:0]      edge_rows [MAX_NODES];
  logic [CNT_W-1:0] node_count_q;
  row_t             rows_due [$];

  int          fail_count;
  int          sent_items;
  int          send_idle_pct;
  int          recv_stall_pct;
  int unsigned cycle_count;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d rows pending", cycle_count, rows_due.size());
      $display("transitive_reduction_bitmatrix: mismatch");
      $finish;
    end
  end

  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    $display("ERROR %0t ns: %s: got %h, expected %h", $time, what, got, want);
    fail_count++;
  endtask

  function automatic int active_rows();
    return (node_count_q > MAX_NODES) ? MAX_NODES : int'(node_count_q);
  endfunction

  // Warshall closure, then in-place reduction; rows keep only loaded edges
  // that survive.
  function automatic void reduce_graph();
    logic [63:0] reach [MAX_NODES];
    logic [63:0] cols;
    int n;
    n = active_rows();
    cols = (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
    for (int i = 0; i < MAX_NODES; i++) reach[i] = (i < n) ? (edge_rows[i] & cols) : '0;
    for (int k = 0; k < n; k++)
      for (int i = 0; i < n; i++)
        if (reach[i][k]) reach[i] |= reach[k];
    for (int j = 0; j < n; j++)
      for (int i = 0; i < n; i++)
        if (reach[i][j]) reach[i] &= ~reach[j];
    for (int i = 0; i < n; i++)
      rows_due.push_back(row_t'{row: IDX_W'(i), succ: edge_rows[i] & reach[i],
                                last: (i == n - 1)});
  endfunction

  function automatic void take_request(input logic [1:0] act, input logic [IDX_W-1:0] src,
                                       input logic [IDX_W-1:0] dst, input chk_e chk,
                                       input logic [IDX_W-1:0] exp_row,
                                       input logic [63:0] exp_succ);
    int n;
    n = active_rows();
    case (act)
      ACT_CLEAR: begin
        for (int i = 0; i < MAX_NODES; i++) edge_rows[i] = '0;
      end
      ACT_EDGE: begin
        edge_rows[src][dst] = 1'b1;
      end
      ACT_RUN: begin
        if (chk == CHK_TYPED) begin
          for (int i = 0; i < n; i++)
            rows_due.push_back(row_t'{row: IDX_W'(i),
                                      succ: (i == exp_row) ? exp_succ : '0,
                                      last: (i == n - 1)});
        end else begin
          reduce_graph();
        end
      end
      default: ;
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance
  // with valid still high, so back-to-back requests need no second drive.
  task automatic send_request(input logic [1:0] act, input logic [IDX_W-1:0] src,
                              input logic [IDX_W-1:0] dst, input chk_e chk,
                              input logic [IDX_W-1:0] exp_row, input logic [63:0] exp_succ);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid  <= 1'b1;
    in_if.action <= act;
    in_if.src    <= src;
    in_if.dst    <= dst;
    do @(posedge clk_i); while (!in_if.ready);
    take_request(act, src, dst, chk, exp_row, exp_succ);
    sent_items++;
    @(negedge clk_i);
  endtask

  task automatic wait_drained(input int tail);
    in_if.valid <= 1'b0;
    while (rows_due.size() != 0) @(negedge clk_i);
    repeat (tail) @(negedge clk_i);
  endtask

  task automatic write_node_count(input logic [CNT_W-1:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
    node_count_q = value;
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic set_idling(input idle_e mode);
    case (mode)
      IDLE_SEND: begin send_idle_pct = 88; recv_stall_pct = 0;  end
      IDLE_RECV: begin send_idle_pct = 0;  recv_stall_pct = 88; end
      IDLE_BOTH: begin send_idle_pct = 8;  recv_stall_pct = 8;  end
      default:   begin send_idle_pct = 0;  recv_stall_pct = 0;  end
    endcase
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (rows_due.size() == 0) begin
        flag_mismatch("row with nothing pending", 64'(out_if.row), '0);
      end else begin
        row_t want;
        want = rows_due.pop_front();
        if (out_if.row !== want.row)
          flag_mismatch("row index", 64'(out_if.row), 64'(want.row));
        if (out_if.successors !== want.succ)
          flag_mismatch($sformatf("successors of row %0d", want.row),
                        out_if.successors, want.succ);
        if (out_if.last !== want.last)
          flag_mismatch($sformatf("last flag of row %0d", want.row),
                        64'(out_if.last), 64'(want.last));
      end
    end
  end

  initial begin
    int goal;
    int lim;
    int n_edges;
    logic [IDX_W-1:0] s;
    logic [IDX_W-1:0] d;

    fail_count     = 0;
    sent_items     = 0;
    cycle_count    = 0;
    node_count_q   = NODE_COUNT_RST;
    for (int i = 0; i < MAX_NODES; i++) edge_rows[i] = '0;
    set_idling(IDLE_NONE);

    rst_ni       = 1'b0;
    in_if.valid  = 1'b0;
    in_if.action = ACT_CLEAR;
    in_if.src    = '0;
    in_if.dst    = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data  = '0;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int t = 0; t < N_DIR; t++) begin
      if (DIR_STEPS[t].kind == STEP_CFG) begin
        wait_drained(SETTLE);
        write_node_count(DIR_STEPS[t].cnt);
      end else begin
        send_request(DIR_STEPS[t].act, DIR_STEPS[t].src, DIR_STEPS[t].dst,
                     DIR_STEPS[t].chk, DIR_STEPS[t].exp_row, DIR_STEPS[t].exp_succ);
      end
    end

    for (int p = 0; p < N_PHASES; p++) begin
      wait_drained(SETTLE);
      set_idling(PHASES[p].mode);
      write_node_count(PHASES[p].cnt);
      lim  = (PHASES[p].cnt > MAX_NODES) ? MAX_NODES : int'(PHASES[p].cnt);
      goal = sent_items + int'(PHASES[p].items);
      while (sent_items < goal) begin
        if ($urandom_range(99) < 10) begin
          // stray request of any kind
          send_request(2'($urandom_range(3)), IDX_W'($urandom), IDX_W'($urandom),
                       CHK_MODEL, '0, '0);
        end else begin
          if ($urandom_range(3) != 0)
            send_request(ACT_CLEAR, IDX_W'($urandom), IDX_W'($urandom), CHK_MODEL, '0, '0);
          n_edges = $urandom_range((2 * lim < 12) ? 2 * lim : 12, 1);
          repeat (n_edges) begin
            if ($urandom_range(9) == 0) begin
              s = IDX_W'($urandom);
              d = IDX_W'($urandom);
            end else begin
              s = IDX_W'($urandom_range(lim - 1, 0));
              d = IDX_W'($urandom_range(lim - 1, 0));
            end
            send_request(ACT_EDGE, s, d, CHK_MODEL, '0, '0);
          end
          send_request(ACT_RUN, IDX_W'($urandom), IDX_W'($urandom), CHK_MODEL, '0, '0);
          if ($urandom_range(3) == 0)
            send_request(ACT_RUN, IDX_W'($urandom), IDX_W'($urandom), CHK_MODEL, '0, '0);
          // now and then hold off until every row of the run is out
          if ($urandom_range(9) == 0)
            wait_drained(0);
        end
      end
    end

    wait_drained(64);
    if (fail_count == 0)
      $display("transitive_reduction_bitmatrix: match");
    else
      $display("transitive_reduction_bitmatrix: mismatch");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+design
design/trbm_pkg.sv
design/trbm_if.sv
design/trbm_ctrl.sv
design/trbm_datapath.sv
design/transitive_reduction_bitmatrix.sv
design/trbm_checker.sv
verif/tb_transitive_reduction_bitmatrix.sv
